@@ rtl/adcc_pkg.sv @@
// shared types, constants and helpers for the adc channel conditioner
package adcc_pkg;

    localparam int unsigned SAMPLE_W = 11;
    localparam int unsigned ROLE_W   = 3;

    // default build values for the top level parameters
    localparam int unsigned SAMPLES_PER_READ_DEF   = 5;
    localparam int unsigned PRESSURE_FRAC_BITS_DEF = 8;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE     = 11'd2047;
    localparam logic [SAMPLE_W-1:0] LIMIT_CURRENT  = 11'd600;
    localparam logic [SAMPLE_W-1:0] LIMIT_PRESSURE = 11'd1500;
    localparam logic [SAMPLE_W-1:0] LIMIT_TEMP     = 11'd2000;

    // apb register map, index taken from paddr[3:2]
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [1:0] REG_HIGH_LIMIT  = 2'd0;
    localparam logic [1:0] REG_LOW_LIMIT   = 2'd1;
    localparam logic [1:0] REG_ZERO_OFFSET = 2'd2;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_SUPPLY12,
        ROLE_MOTOR_VOLT,
        ROLE_MOTOR_CURRENT,
        ROLE_PRESSURE,
        ROLE_SPARE,
        ROLE_TEMP,
        ROLE_V5,
        ROLE_VDD
    } role_t;

    typedef struct packed {
        logic [ROLE_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [ROLE_W-1:0]   channel_out;
        logic [SAMPLE_W-1:0] burst_average;
        logic                sample_accepted;
        logic                full_scale_error;
        logic [SAMPLE_W-1:0] published_value;
        logic                press_above_high;
        logic                pressure_stall;
        logic [6:0]          battery_percent;
        logic signed [15:0]  temperature_c;
        logic [5:0]          pressure_psi;
    } out_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] high_limit;
        logic [SAMPLE_W-1:0] low_limit;
        logic [SAMPLE_W-1:0] zero_offset;
    } cfg_t;

    // record handed from the filter stage to the conversion stage
    typedef struct packed {
        logic [ROLE_W-1:0]   channel;
        logic [SAMPLE_W-1:0] avg;
        logic                accepted;
        logic                full_scale_error;
        logic [SAMPLE_W-1:0] published;
        logic [SAMPLE_W-1:0] supply;
        logic [SAMPLE_W-1:0] pressure;
        logic [SAMPLE_W-1:0] temp;
    } filt_rec_t;

    // acceptance limit per role, spare has none
    function automatic logic [SAMPLE_W-1:0] accept_limit(input role_t r);
        logic [SAMPLE_W-1:0] lim;
        case (r)
            ROLE_SUPPLY12, ROLE_MOTOR_VOLT, ROLE_V5, ROLE_VDD: lim = FULL_SCALE;
            ROLE_MOTOR_CURRENT: lim = LIMIT_CURRENT;
            ROLE_PRESSURE:      lim = LIMIT_PRESSURE;
            ROLE_TEMP:          lim = LIMIT_TEMP;
            default:            lim = '0;
        endcase
        return lim;
    endfunction

endpackage

@@ rtl/adcc_regs.sv @@
// apb configuration registers for the pressure window and zero offset
module adcc_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [adcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [adcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [adcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output adcc_pkg::cfg_t                   cfg
);
    import adcc_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_HIGH_LIMIT:  cfg_reg.high_limit  <= pwdata[SAMPLE_W-1:0];
                REG_LOW_LIMIT:   cfg_reg.low_limit   <= pwdata[SAMPLE_W-1:0];
                REG_ZERO_OFFSET: cfg_reg.zero_offset <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_HIGH_LIMIT:  prdata = APB_DATA_W'(cfg_reg.high_limit);
            REG_LOW_LIMIT:   prdata = APB_DATA_W'(cfg_reg.low_limit);
            REG_ZERO_OFFSET: prdata = APB_DATA_W'(cfg_reg.zero_offset);
            default:         prdata = '0;
        endcase
    end

endmodule

@@ rtl/adcc_accum.sv @@
// burst accumulator: sums conversions and hands over the completed burst sum
module adcc_accum #(
    parameter int unsigned SAMPLES_PER_READ = adcc_pkg::SAMPLES_PER_READ_DEF,
    parameter int unsigned SUM_W            = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  adcc_pkg::in_item_t            s_data,
    output logic                          a_valid,
    input  logic                          a_ready,
    output logic [adcc_pkg::ROLE_W-1:0]   a_role,
    output logic [SUM_W-1:0]              a_sum
);
    import adcc_pkg::*;

    localparam int unsigned CNT_W = (SAMPLES_PER_READ > 1) ? $clog2(SAMPLES_PER_READ) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_READ - 1);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_reg;
    logic              a_valid_reg;
    logic [ROLE_W-1:0] a_role_reg;
    logic [SUM_W-1:0]  a_sum_reg;
    logic              take;
    logic              last;

    assign s_ready  = !a_valid_reg || a_ready;
    assign take     = s_valid && s_ready;
    assign last     = (count_reg == LAST_CNT);
    assign sum_next = sum_reg + SUM_W'(s_data.sample);

    assign a_valid = a_valid_reg;
    assign a_role  = a_role_reg;
    assign a_sum   = a_sum_reg;

    // running sum, burst position and handover flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (a_valid_reg && a_ready) begin
                a_valid_reg <= 1'b0;
            end
            if (take) begin
                if (last) begin
                    sum_reg     <= '0;
                    count_reg   <= '0;
                    a_valid_reg <= 1'b1;
                end else begin
                    sum_reg   <= sum_next;
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // completed burst payload, role from the last transfer
    always_ff @(posedge aclk) begin
        if (take && last) begin
            a_role_reg <= s_data.channel;
            a_sum_reg  <= sum_next;
        end
    end

endmodule

@@ rtl/adcc_filter.sv @@
// burst average, acceptance check, role values and exponential averages of four roles
module adcc_filter #(
    parameter int unsigned SAMPLES_PER_READ   = adcc_pkg::SAMPLES_PER_READ_DEF,
    parameter int unsigned PRESSURE_FRAC_BITS = adcc_pkg::PRESSURE_FRAC_BITS_DEF,
    parameter int unsigned SUM_W              = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          a_valid,
    output logic                          a_ready,
    input  logic [adcc_pkg::ROLE_W-1:0]   a_role,
    input  logic [SUM_W-1:0]              a_sum,
    output logic                          rec_valid,
    input  logic                          rec_ready,
    output adcc_pkg::filt_rec_t           rec
);
    import adcc_pkg::*;

    localparam int unsigned NUM_ROLES = 2 ** ROLE_W;
    localparam int unsigned PAVG_W    = SAMPLE_W + PRESSURE_FRAC_BITS;
    // reciprocal of the burst length, exact for any sum below 2**SUM_W and up to 8 samples
    localparam int unsigned DIV_SHIFT = SUM_W + 3;
    localparam int unsigned MULT_W    = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + SAMPLES_PER_READ - 1) / SAMPLES_PER_READ);

    logic [SAMPLE_W-1:0] role_reg [NUM_ROLES];
    logic [SAMPLE_W-1:0] role_next [NUM_ROLES];
    logic [SAMPLE_W-1:0] supply_avg_reg, current_avg_reg, temp_avg_reg;
    logic [SAMPLE_W-1:0] supply_avg_next, current_avg_next, temp_avg_next;
    logic [PAVG_W-1:0]   press_avg_reg, press_avg_next;
    logic                rec_valid_reg;
    filt_rec_t           rec_reg;
    filt_rec_t           rec_next;

    logic [PROD_W-1:0]   div_prod;
    logic [SUM_W-1:0]    quot;
    logic [SAMPLE_W-1:0] avg;
    role_t               role;
    logic                accepted;
    logic                fire;
    logic [SAMPLE_W+1:0] sup3, cur3;
    logic [SAMPLE_W+3:0] tmp15;
    logic [PAVG_W+1:0]   press3;
    logic [SAMPLE_W-1:0] sup_new, cur_new, tmp_new;
    logic [PAVG_W-1:0]   press_new;

    assign a_ready   = !rec_valid_reg || rec_ready;
    assign fire      = a_valid && a_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    // truncated burst mean by reciprocal multiplication, then acceptance
    assign div_prod = PROD_W'(a_sum) * PROD_W'(DIV_MULT);
    assign quot     = div_prod[PROD_W-2:DIV_SHIFT];
    assign avg      = (quot > SUM_W'(FULL_SCALE)) ? FULL_SCALE : quot[SAMPLE_W-1:0];
    assign role     = role_t'(a_role);
    assign accepted = (role == ROLE_SPARE) || (avg < accept_limit(role));

    // 3/4 averages for supply and current
    assign sup3    = {2'b00, supply_avg_reg} + {1'b0, supply_avg_reg, 1'b0};
    assign sup_new = sup3[SAMPLE_W+1:2] + {2'b00, avg[SAMPLE_W-1:2]};
    assign cur3    = {2'b00, current_avg_reg} + {1'b0, current_avg_reg, 1'b0};
    assign cur_new = cur3[SAMPLE_W+1:2] + {2'b00, avg[SAMPLE_W-1:2]};

    // 15/16 average for temperature
    assign tmp15   = {temp_avg_reg, 4'b0000} - {4'b0000, temp_avg_reg};
    assign tmp_new = tmp15[SAMPLE_W+3:4] + {4'b0000, avg[SAMPLE_W-1:4]};

    // 3/4 fixed point average for pressure
    assign press3    = {2'b00, press_avg_reg} + {1'b0, press_avg_reg, 1'b0};
    assign press_new = press3[PAVG_W+1:2] + (PAVG_W'(avg) << (PRESSURE_FRAC_BITS - 2));

    // next role values and average state
    always_comb begin
        for (int i = 0; i < NUM_ROLES; i++) begin
            role_next[i] = role_reg[i];
        end
        supply_avg_next  = supply_avg_reg;
        current_avg_next = current_avg_reg;
        temp_avg_next    = temp_avg_reg;
        press_avg_next   = press_avg_reg;
        if (accepted) begin
            case (role)
                ROLE_SUPPLY12: begin
                    supply_avg_next         = sup_new;
                    role_next[ROLE_SUPPLY12] = sup_new;
                end
                ROLE_MOTOR_CURRENT: begin
                    current_avg_next              = cur_new;
                    role_next[ROLE_MOTOR_CURRENT] = cur_new;
                end
                ROLE_PRESSURE: begin
                    press_avg_next           = press_new;
                    role_next[ROLE_PRESSURE] = press_new[PAVG_W-1:PRESSURE_FRAC_BITS];
                end
                ROLE_TEMP: begin
                    temp_avg_next        = tmp_new;
                    role_next[ROLE_TEMP] = tmp_new;
                end
                default: begin
                    role_next[a_role] = avg;
                end
            endcase
        end
    end

    // record for the conversion stage
    always_comb begin
        rec_next.channel          = a_role;
        rec_next.avg              = avg;
        rec_next.accepted         = accepted;
        rec_next.full_scale_error = (avg == FULL_SCALE) && (role != ROLE_SPARE);
        rec_next.published        = role_next[a_role];
        rec_next.supply           = role_next[ROLE_SUPPLY12];
        rec_next.pressure         = role_next[ROLE_PRESSURE];
        rec_next.temp             = role_next[ROLE_TEMP];
    end

    // filter state and record valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ROLES; i++) begin
                role_reg[i] <= '0;
            end
            supply_avg_reg  <= '0;
            current_avg_reg <= '0;
            temp_avg_reg    <= '0;
            press_avg_reg   <= '0;
            rec_valid_reg   <= 1'b0;
        end else begin
            if (rec_valid_reg && rec_ready) begin
                rec_valid_reg <= 1'b0;
            end
            if (fire) begin
                for (int i = 0; i < NUM_ROLES; i++) begin
                    role_reg[i] <= role_next[i];
                end
                supply_avg_reg  <= supply_avg_next;
                current_avg_reg <= current_avg_next;
                temp_avg_reg    <= temp_avg_next;
                press_avg_reg   <= press_avg_next;
                rec_valid_reg   <= 1'b1;
            end
        end
    end

    // record payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            rec_reg <= rec_next;
        end
    end

endmodule

@@ rtl/adcc_convert.sv @@
// unit conversions, pressure window flags and the result register
module adcc_convert (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  adcc_pkg::filt_rec_t   rec,
    input  adcc_pkg::cfg_t        cfg,
    output logic                  m_valid,
    input  logic                  m_ready,
    output adcc_pkg::out_item_t   m_data
);
    import adcc_pkg::*;

    // battery: mv = supply*20 - 100, percent = (mv - 9000) / 30 inside the window
    localparam logic [15:0] BATT_MV_PER_LSB = 16'd20;
    localparam logic [15:0] BATT_RAW_LOW    = 16'd9100;
    localparam logic [15:0] BATT_RAW_HIGH   = 16'd12100;
    localparam logic [11:0] RECIP_30        = 12'd2185;
    localparam int unsigned RECIP_SHIFT     = 16;
    localparam logic [6:0]  BATT_FULL       = 7'd100;
    // temperature and pressure scaling
    localparam logic [15:0]        TEMP_SCALE  = 16'd13;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd1000;
    localparam logic [17:0]        PSI_SCALE   = 18'd69;
    localparam logic [6:0]         PSI_MAX     = 7'd63;

    logic      m_valid_reg;
    out_item_t m_data_reg;
    out_item_t m_data_next;
    logic      load;

    logic [15:0]         mv20;
    logic [11:0]         batt_diff;
    logic [23:0]         batt_prod;
    logic [6:0]          batt_pct;
    logic [15:0]         temp13;
    logic [SAMPLE_W-1:0] psi_diff;
    logic [17:0]         psi_prod;
    logic [6:0]          psi_full;
    logic                ok;

    assign rec_ready = !m_valid_reg || m_ready;
    assign load      = rec_valid && rec_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // battery percent
    assign mv20      = {5'b00000, rec.supply} * BATT_MV_PER_LSB;
    assign batt_diff = 12'(mv20 - BATT_RAW_LOW);
    assign batt_prod = batt_diff * RECIP_30;
    always_comb begin
        if (mv20 < BATT_RAW_LOW) begin
            batt_pct = '0;
        end else if (mv20 > BATT_RAW_HIGH) begin
            batt_pct = BATT_FULL;
        end else begin
            batt_pct = 7'(batt_prod >> RECIP_SHIFT);
        end
    end

    // temperature in celsius
    assign temp13 = {5'b00000, rec.temp} * TEMP_SCALE;

    // pressure in psi, floored at the zero offset and capped
    assign psi_diff = rec.pressure - cfg.zero_offset;
    assign psi_prod = {7'b0000000, psi_diff} * PSI_SCALE;
    assign psi_full = psi_prod[17:11];

    assign ok = rec.pressure > cfg.high_limit;

    always_comb begin
        m_data_next.channel_out      = rec.channel;
        m_data_next.burst_average    = rec.avg;
        m_data_next.sample_accepted  = rec.accepted;
        m_data_next.full_scale_error = rec.full_scale_error;
        m_data_next.published_value  = rec.published;
        m_data_next.press_above_high = ok;
        m_data_next.pressure_stall   = !ok && (rec.pressure < cfg.low_limit);
        m_data_next.battery_percent  = batt_pct;
        m_data_next.temperature_c    = $signed(temp13) - TEMP_OFFSET;
        if (rec.pressure < cfg.zero_offset) begin
            m_data_next.pressure_psi = '0;
        end else if (psi_full > PSI_MAX) begin
            m_data_next.pressure_psi = PSI_MAX[5:0];
        end else begin
            m_data_next.pressure_psi = psi_full[5:0];
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ rtl/adc_channel_conditioner_core.sv @@
// adc channel conditioner top: burst accumulator, role filters, conversions, apb registers
// a burst result is registered in the accumulator, the filter record and the result register in turn
// throughput: one input transfer per cycle while s_ready is high; one result per SAMPLES_PER_READ transfers
// the three stages (accumulator, filter, result register) each hold one item under backpressure
// reset: synchronous active-low aresetn clears sums, filter state, role values and registers
module adc_channel_conditioner_core #(
    parameter int unsigned SAMPLES_PER_READ   = adcc_pkg::SAMPLES_PER_READ_DEF,
    parameter int unsigned PRESSURE_FRAC_BITS = adcc_pkg::PRESSURE_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  adcc_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output adcc_pkg::out_item_t              m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [adcc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [adcc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [adcc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import adcc_pkg::*;

    localparam int unsigned SUM_W = $clog2(SAMPLES_PER_READ * 2047 + 1);

    logic              a_valid;
    logic              a_ready;
    logic [ROLE_W-1:0] a_role;
    logic [SUM_W-1:0]  a_sum;
    logic              rec_valid;
    logic              rec_ready;
    filt_rec_t         rec;
    cfg_t              cfg;

    adcc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adcc_accum #(
        .SAMPLES_PER_READ (SAMPLES_PER_READ),
        .SUM_W            (SUM_W)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .a_valid (a_valid),
        .a_ready (a_ready),
        .a_role  (a_role),
        .a_sum   (a_sum)
    );

    adcc_filter #(
        .SAMPLES_PER_READ   (SAMPLES_PER_READ),
        .PRESSURE_FRAC_BITS (PRESSURE_FRAC_BITS),
        .SUM_W              (SUM_W)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .a_valid   (a_valid),
        .a_ready   (a_ready),
        .a_role    (a_role),
        .a_sum     (a_sum),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    adcc_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .cfg       (cfg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a new result only appears after the filter stage held a record
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(rec_valid))
        else $error("result raised without a filter record");

    // a full-scale average is never below any role limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.full_scale_error |-> !m_data.sample_accepted)
        else $error("full-scale burst was accepted");

    // the spare role is never rejected
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.channel_out == ROLE_SPARE) |-> m_data.sample_accepted)
        else $error("spare burst rejected");

    // battery percent stays within its range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.battery_percent <= 7'd100))
        else $error("battery percent out of range");

endmodule
